// ===== hdl/linear_search_transpose_defines.svh =====
// ----------------------------------------------------------------------------
// linear_search_transpose assertion macros
// shared property forms for the checker of the self-organizing store
// ----------------------------------------------------------------------------
`ifndef LINEAR_SEARCH_TRANSPOSE_DEFINES_SVH
`define LINEAR_SEARCH_TRANSPOSE_DEFINES_SVH

// same-cycle implication
`define LST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define LST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/lst_pkg.sv =====
// ----------------------------------------------------------------------------
// lst_pkg
// shared constants and codes of the self-organizing store
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VALUE_W   = 32;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int M_TDATA_W = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

endpackage

// ===== hdl/linear_search_transpose.sv =====
// ----------------------------------------------------------------------------
// linear_search_transpose
// self-organizing store of signed 32-bit entries, transpose heuristic
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)          | tuser (low bit up)
//  ---------+-----+-----------------------------+-------------------------
//  s_axis   | in  | value[31:0]                 | operation[1:0]
//  m_axis   | out | position[3:0], 4'b0 pad     | status[1:0]
//
//  clear, append and unknown codes: result register loads from the accepted word,
//  then the output register loads from it once it is free
//  search: one ram read per entry during the scan, then the swap write-back
//  on a hit above slot zero, then output
//  the ram read port sets the scan rate; one word is in work at a time
//  reset clears control state and fill count only; ram contents stay
//  a stalled output word holds; the next input word is taken once the
//  result has moved into the output register
//
module linear_search_transpose
#(
  parameter int DEPTH = lst_pkg::DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  // input words
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [lst_pkg::VALUE_W-1:0] s_axis_tdata,   // value
  input  logic [lst_pkg::OP_W-1:0]    s_axis_tuser,   // operation
  // result words
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [lst_pkg::M_TDATA_W-1:0] m_axis_tdata, // position, zero pad
  output logic [lst_pkg::STATUS_W-1:0]  m_axis_tuser  // status
);

  import lst_pkg::*;

  typedef enum logic [1:0] {IDLE, SCAN, SWAP, RESP} state_t;

  state_t state;

  // control
  logic [CW-1:0]       fill_count;
  logic [CW-1:0]       issue_idx;    // next slot to read
  logic                rd_vld;       // ram read data is valid this cycle
  logic [AW-1:0]       rd_idx;       // slot of the data on the read port
  logic [AW-1:0]       hit_idx;

  // payload
  logic [VALUE_W-1:0]  key;
  logic [VALUE_W-1:0]  prev_data;    // entry just before rd_idx
  logic [STATUS_W-1:0] res_status;
  logic [POS_W-1:0]    res_pos;

  // ram port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [VALUE_W-1:0]  ram_rdata;

  logic in_acc;
  logic scan_issue;
  logic hit;
  logic not_full;
  logic out_free;
  logic out_load;

  assign s_axis_tready = (state == IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign not_full      = (fill_count < CW'(DEPTH));
  assign scan_issue    = (state == SCAN) && (issue_idx < fill_count);
  assign hit           = (state == SCAN) && rd_vld && (ram_rdata == key);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = (state == RESP) && out_free;

  // write port: append, first half of the swap in the hit cycle, second half after
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_count[AW-1:0];
    ram_wdata = s_axis_tdata;
    if (in_acc && (s_axis_tuser == OP_APPEND) && not_full) begin
      ram_we = 1'b1;
    end else if (hit && (rd_idx != '0)) begin
      // found entry moves one slot toward the front
      ram_we    = 1'b1;
      ram_waddr = rd_idx - AW'(1);
      ram_wdata = key;
    end else if (state == SWAP) begin
      ram_we    = 1'b1;
      ram_waddr = hit_idx;
      ram_wdata = prev_data;
    end
  end

  lst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      fill_count    <= '0;
      issue_idx     <= '0;
      rd_vld        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // scan pipeline: address this cycle, data and compare next cycle
      rd_vld <= scan_issue;
      rd_idx <= issue_idx[AW-1:0];
      if (scan_issue) begin
        issue_idx <= issue_idx + CW'(1);
      end
      if (rd_vld && !hit) begin
        prev_data <= ram_rdata;
      end

      // output register
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tuser  <= res_status;
        m_axis_tdata  <= M_TDATA_W'(res_pos);
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_acc) begin
            key       <= s_axis_tdata;
            issue_idx <= '0;
            unique case (s_axis_tuser)
              OP_CLEAR: begin
                fill_count <= '0;
                res_status <= ST_DONE;
                res_pos    <= '0;
                state      <= RESP;
              end
              OP_APPEND: begin
                state <= RESP;
                if (not_full) begin
                  res_status <= ST_DONE;
                  res_pos    <= POS_W'(fill_count);
                  fill_count <= fill_count + CW'(1);
                end else begin
                  res_status <= ST_FULL;
                  res_pos    <= '0;
                end
              end
              OP_SEARCH: begin
                state <= SCAN;
              end
              default: begin
                // unused code: no change
                res_status <= ST_DONE;
                res_pos    <= '0;
                state      <= RESP;
              end
            endcase
          end
        end
        SCAN: begin
          if (hit) begin
            res_status <= ST_DONE;
            res_pos    <= POS_W'(rd_idx);
            hit_idx    <= rd_idx;
            state      <= (rd_idx != '0) ? SWAP : RESP;
          end else if (!scan_issue && !rd_vld) begin
            // every slot below fill count compared, no match
            res_status <= ST_NOTFOUND;
            res_pos    <= '0;
            state      <= RESP;
          end
        end
        SWAP: begin
          state <= RESP;
        end
        RESP: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/lst_ram.sv =====
// ----------------------------------------------------------------------------
// lst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lst_checker.sv =====
// ----------------------------------------------------------------------------
// lst_sva
// port-level checks of the self-organizing store, bound to the top level
// ----------------------------------------------------------------------------
`include "linear_search_transpose_defines.svh"

module lst_sva (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [lst_pkg::OP_W-1:0]      s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lst_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [lst_pkg::STATUS_W-1:0]  m_axis_tuser
);

  import lst_pkg::*;

  logic status_ok;
  logic pad_zero;
  logic in_acc;

  assign status_ok = (m_axis_tuser == ST_DONE) || (m_axis_tuser == ST_NOTFOUND) ||
                     (m_axis_tuser == ST_FULL);
  assign pad_zero  = (m_axis_tdata[M_TDATA_W-1:POS_W] == '0);
  assign in_acc    = s_axis_tvalid && s_axis_tready && (s_axis_tuser == s_axis_tuser);

  // one word in work at a time
  `LST_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_acc, !s_axis_tready)

  // a stalled result stays offered
  `LST_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // only defined status codes
  `LST_ASSERT_IMPLY(a_status_code, clk, rst, m_axis_tvalid, status_ok)

  // pad bits stay zero
  `LST_ASSERT_IMPLY(a_pad_zero, clk, rst, m_axis_tvalid, pad_zero)

  // miss and full results carry slot zero
  `LST_ASSERT_IMPLY(a_pos_zero, clk, rst, m_axis_tvalid && (m_axis_tuser != ST_DONE), m_axis_tdata == '0)

endmodule

bind linear_search_transpose lst_sva u_lst_sva (.*);
